### hw/rtl/ilt_pkg.sv
// Shared types and constants for the INI line tokenizer.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package ilt_pkg;

	// Character constants
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharTab   = 8'h09;
	localparam logic [7:0] CharNul   = 8'h00;

	// Result queue depth (power of two, at least four)
	localparam int ResDepth = 4;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_SEC_OPEN  = 3'd0,
		CFG_SEC_CLOSE = 3'd1,
		CFG_ASSIGN    = 3'd2,
		CFG_CMT_FIRST = 3'd3,
		CFG_CMT_SECOND = 3'd4,
		CFG_CMT_THIRD = 3'd5,
		CFG_WANT_MODE = 3'd6
	} cfg_idx_t;

	// Want mode codes
	typedef enum logic [1:0] {
		WANT_ALL      = 2'd0,
		WANT_SECTIONS = 2'd1,
		WANT_KEYS     = 2'd2,
		WANT_NONE     = 2'd3
	} want_t;

	// Token kinds
	typedef enum logic [1:0] {
		TK_SECTION  = 2'd0,
		TK_KEY      = 2'd1,
		TK_VALUE    = 2'd2,
		TK_LINE_END = 2'd3
	} kind_t;

	// Line classes
	typedef enum logic [2:0] {
		CLS_EMPTY   = 3'd0,
		CLS_COMMENT = 3'd1,
		CLS_SECTION = 3'd2,
		CLS_KEY     = 3'd3,
		CLS_KEYVAL  = 3'd4
	} class_t;

	// Parser phases
	typedef enum logic [2:0] {
		PH_LEAD     = 3'd0,
		PH_SEC_LEAD = 3'd1,
		PH_SEC      = 3'd2,
		PH_KEY      = 3'd3,
		PH_VAL_LEAD = 3'd4,
		PH_VAL      = 3'd5,
		PH_IGNORE   = 3'd6
	} phase_t;

	// Configuration register set
	typedef struct packed {
		logic [7:0] sec_open;
		logic [7:0] sec_close;
		logic [7:0] assign_ch;
		logic [7:0] cmt_first;
		logic [7:0] cmt_second;
		logic [7:0] cmt_third;
		want_t      want;
	} cfg_t;

	// One result item
	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		class_t     cls;
		logic       last;
	} res_t;

endpackage

`default_nettype wire

### hw/rtl/ini_line_tokenizer_unit.sv
// INI line tokenizer, top level: input register, parser and result queue.
// Depends on ilt_pkg, ilt_cfg_regs, ilt_parse, ilt_res_fifo.
//
// Usage:
//   Input channel (in_valid/in_ready) carries data_byte and end_of_line, one
//   character or one line end per transaction. Output channel (out_valid/
//   out_ready) carries token_kind, char_out, line_class and last; an input
//   transaction yields zero, one or two results, the final one flagged by last.
//   Config channel (cfg_valid/cfg_ready) writes register cfg_index with
//   cfg_data; cfg_ready is always high. Write only while the block is idle.
// Timing:
//   An accepted item sits in the input register, is parsed there and its
//   results enter the four-entry result queue; the first result shows on the
//   output once the item has passed the input register and been written to
//   the queue. One item per cycle is taken as long as each item yields at most
//   one result and the receiver keeps out_ready high; the queue drains one
//   result a cycle, and a collapsed space plus its character are two results.
// Reset: arst_n clears the parser to line start, empties the queue and loads
//   the default register values. When the receiver stalls, the queue fills and
//   in_ready drops while the input register is held and fewer than two entries
//   would be free after this cycle's read.
`default_nettype none

module ini_line_tokenizer_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input channel
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   data_byte,
	input  wire logic         end_of_line,
	// output channel
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [1:0]        token_kind,
	output logic [7:0]        char_out,
	output logic [2:0]        line_class,
	output logic              last,
	// configuration channel
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [7:0]   cfg_data
);
	import ilt_pkg::*;

	cfg_t       cfg;
	logic       s1_valid_q;
	logic [7:0] byte_s1;
	logic       eol_s1;
	logic       step_en, room2;
	logic [1:0] n_res;
	res_t       res0, res1, rd_data;

	assign cfg_ready = 1'b1;

	ilt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Input register: refills in the cycle its item is parsed
	assign step_en  = s1_valid_q && room2;
	assign in_ready = !s1_valid_q || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eol_s1  <= end_of_line;
		end
	end

	ilt_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (step_en),
		.byte_in (byte_s1),
		.eol_in  (eol_s1),
		.n_res   (n_res),
		.res0    (res0),
		.res1    (res1)
	);

	ilt_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.n_wr     (step_en ? n_res : 2'd0),
		.wr0      (res0),
		.wr1      (res1),
		.room2    (room2),
		.rd_valid (out_valid),
		.rd_ready (out_ready),
		.rd_data  (rd_data)
	);

	assign token_kind = rd_data.kind;
	assign char_out   = rd_data.ch;
	assign line_class = rd_data.cls;
	assign last       = rd_data.last;

	// A parsed line end always leaves a result to deliver
	a_eol_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && eol_s1 |=> out_valid)
		else $error("line end parsed but no result queued");

	// Line-end results are final and carry no character
	a_eol_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == TK_LINE_END) |-> last && (char_out == CharNul))
		else $error("malformed line-end result");

	// Only a collapsed space precedes another result of the same item
	a_pair_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> (char_out == CharSpace) && (token_kind != TK_LINE_END))
		else $error("non-final result is not a collapsed space");

endmodule

`default_nettype wire

### hw/rtl/ilt_cfg_regs.sv
// Configuration register file of the INI line tokenizer.
// Depends on ilt_pkg.
`default_nettype none

module ilt_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [2:0]   wr_index,
	input  wire logic [7:0]   wr_data,
	output ilt_pkg::cfg_t     cfg
);
	import ilt_pkg::*;

	cfg_t cfg_q;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sec_open   <= 8'd91;
			cfg_q.sec_close  <= 8'd93;
			cfg_q.assign_ch  <= 8'd61;
			cfg_q.cmt_first  <= 8'd35;
			cfg_q.cmt_second <= 8'd42;
			cfg_q.cmt_third  <= 8'd59;
			cfg_q.want       <= WANT_ALL;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_SEC_OPEN:   cfg_q.sec_open   <= wr_data;
				CFG_SEC_CLOSE:  cfg_q.sec_close  <= wr_data;
				CFG_ASSIGN:     cfg_q.assign_ch  <= wr_data;
				CFG_CMT_FIRST:  cfg_q.cmt_first  <= wr_data;
				CFG_CMT_SECOND: cfg_q.cmt_second <= wr_data;
				CFG_CMT_THIRD:  cfg_q.cmt_third  <= wr_data;
				CFG_WANT_MODE:  cfg_q.want       <= want_t'(wr_data[1:0]);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/ilt_parse.sv
// Line parser: phase, pending-space and class registers plus the per-byte step logic.
// Produces zero, one or two results per stepped transaction. Depends on ilt_pkg.
`default_nettype none

module ilt_parse (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ilt_pkg::cfg_t cfg,
	input  wire logic         step_en,
	input  wire logic [7:0]   byte_in,
	input  wire logic         eol_in,
	output logic [1:0]        n_res,
	output ilt_pkg::res_t     res0,
	output ilt_pkg::res_t     res1
);
	import ilt_pkg::*;

	phase_t phase_q, phase_d;
	logic   pend_q, pend_d;
	class_t cls_q, cls_d;

	logic   blank, is_cmt, want_sec, want_key;
	logic   emit_sp, emit_ch;
	kind_t  kind;

	// Byte classification
	assign blank    = (byte_in == CharSpace) || (byte_in == CharTab);
	assign is_cmt   = ((cfg.cmt_first  != CharNul) && (byte_in == cfg.cmt_first))  ||
	                  ((cfg.cmt_second != CharNul) && (byte_in == cfg.cmt_second)) ||
	                  ((cfg.cmt_third  != CharNul) && (byte_in == cfg.cmt_third));
	assign want_sec = (cfg.want == WANT_ALL) || (cfg.want == WANT_SECTIONS);
	assign want_key = (cfg.want == WANT_ALL) || (cfg.want == WANT_KEYS);

	// Next state and emitted characters
	always_comb begin
		phase_d = phase_q;
		pend_d  = pend_q;
		cls_d   = cls_q;
		emit_sp = 1'b0;
		emit_ch = 1'b0;
		kind    = TK_KEY;
		if (eol_in) begin
			phase_d = PH_LEAD;
			pend_d  = 1'b0;
			cls_d   = CLS_EMPTY;
		end else begin
			case (phase_q)
				PH_LEAD: begin
					if (!blank) begin
						if (byte_in == cfg.sec_open) begin
							cls_d   = CLS_SECTION;
							phase_d = want_sec ? PH_SEC_LEAD : PH_IGNORE;
						end else if (is_cmt) begin
							cls_d   = CLS_COMMENT;
							phase_d = PH_IGNORE;
						end else begin
							cls_d  = CLS_KEY;
							pend_d = 1'b0;
							if (!want_key) begin
								phase_d = PH_IGNORE;
							end else if (byte_in == cfg.assign_ch) begin
								// empty key, value follows
								cls_d   = CLS_KEYVAL;
								phase_d = PH_VAL_LEAD;
							end else begin
								phase_d = PH_KEY;
								emit_ch = 1'b1;
								kind    = TK_KEY;
							end
						end
					end
				end
				PH_SEC_LEAD: begin
					if (!blank) begin
						if (byte_in == cfg.sec_close) begin
							phase_d = PH_IGNORE;
						end else begin
							emit_ch = 1'b1;
							kind    = TK_SECTION;
							phase_d = PH_SEC;
						end
					end
				end
				PH_SEC: begin
					if (blank) begin
						pend_d = 1'b1;
					end else if (byte_in == cfg.sec_close) begin
						pend_d  = 1'b0;
						phase_d = PH_IGNORE;
					end else begin
						emit_sp = pend_q;
						emit_ch = 1'b1;
						kind    = TK_SECTION;
						pend_d  = 1'b0;
					end
				end
				PH_KEY: begin
					if (blank) begin
						pend_d = 1'b1;
					end else if (byte_in == cfg.assign_ch) begin
						cls_d   = CLS_KEYVAL;
						pend_d  = 1'b0;
						phase_d = PH_VAL_LEAD;
					end else begin
						emit_sp = pend_q;
						emit_ch = 1'b1;
						kind    = TK_KEY;
						pend_d  = 1'b0;
					end
				end
				PH_VAL_LEAD: begin
					if (!blank) begin
						emit_ch = 1'b1;
						kind    = TK_VALUE;
						phase_d = PH_VAL;
					end
				end
				PH_VAL: begin
					emit_ch = 1'b1;
					kind    = TK_VALUE;
				end
				default: ;
			endcase
		end
	end

	// Result assembly: a line end reports the class it closes
	always_comb begin
		res0 = '{kind: TK_LINE_END, ch: CharNul, cls: cls_q, last: 1'b1};
		res1 = '{kind: kind, ch: byte_in, cls: cls_d, last: 1'b1};
		n_res = 2'd0;
		if (eol_in) begin
			n_res = 2'd1;
		end else if (emit_sp) begin
			res0  = '{kind: kind, ch: CharSpace, cls: cls_d, last: 1'b0};
			n_res = 2'd2;
		end else if (emit_ch) begin
			res0  = '{kind: kind, ch: byte_in, cls: cls_d, last: 1'b1};
			n_res = 2'd1;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			pend_q  <= 1'b0;
			cls_q   <= CLS_EMPTY;
		end else if (step_en) begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
			cls_q   <= cls_d;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ilt_res_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per cycle while rd_ready is high.
// Register-based, ResDepth entries. Depends on ilt_pkg.
`default_nettype none

module ilt_res_fifo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [1:0]   n_wr,
	input  wire ilt_pkg::res_t wr0,
	input  wire ilt_pkg::res_t wr1,
	output logic              room2,
	output logic              rd_valid,
	input  wire logic         rd_ready,
	output ilt_pkg::res_t     rd_data
);
	import ilt_pkg::*;

	localparam int AW = $clog2(ResDepth);
	localparam int CW = $clog2(ResDepth + 1);

	res_t          mem_q [ResDepth];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q, cnt_after_pop;
	logic          pop;

	assign pop           = rd_valid && rd_ready;
	assign cnt_after_pop = cnt_q - CW'(pop);
	assign room2         = cnt_after_pop <= CW'(ResDepth - 2);
	assign rd_valid      = cnt_q != '0;
	assign rd_data       = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (n_wr != 2'd0) begin
			mem_q[wr_ptr_q] <= wr0;
		end
		if (n_wr == 2'd2) begin
			mem_q[wr_ptr_q + AW'(1)] <= wr1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(n_wr);
			rd_ptr_q <= rd_ptr_q + AW'(pop);
			cnt_q    <= cnt_after_pop + CW'(n_wr);
		end
	end

endmodule

`default_nettype wire

### test/tb_ini_line_tokenizer_unit.sv
// Self-checking testbench for ini_line_tokenizer_unit: streams INI text, rewrites the
// marker registers between phases and checks every token against a behavioral predictor.
// Depends on ilt_pkg and the tokenizer RTL; reads and writes no files.

module tb_ini_line_tokenizer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ilt_pkg::*;

	localparam int SETTLE_CYCLES = 8;       // covers the input register and result queue with margin
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_ITEMS   = 50;
	localparam int NUM_PHASES    = 8;

	// Entries of the stimulus queue
	typedef enum logic [1:0] {
		FEED_CHAR,
		FEED_PAUSE,
		FEED_REG_WRITE,
		FEED_WAIT_IDLE
	} feed_kind_e;

	typedef struct {
		feed_kind_e kind;
		logic [7:0] b;
		logic       eol;
		cfg_idx_t   idx;
		logic [7:0] val;
		int         gap;
	} feed_op_t;

	// DUT ports
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       end_of_line = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] token_kind;
	logic [7:0] char_out;
	logic [2:0] line_class;
	logic       last;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	cfg_idx_t   cfg_index = CFG_SEC_OPEN;
	logic [7:0] cfg_data = 8'h00;

	// Predictor state
	cfg_t     model_cfg;
	cfg_t     plan_cfg;          // register values as the stimulus is being planned
	phase_t   line_phase;
	logic     space_owed;
	class_t   line_cls;
	res_t     item_tokens[$];
	res_t     expected_tokens[$];
	feed_op_t text_feed[$];

	int planned_items = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int pause_left = 0;
	int quiet_cycles = 0;
	int rx_stall = 0;
	int mismatches = 0;
	int cycle_cnt = 0;

	ini_line_tokenizer_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.end_of_line (end_of_line),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_kind  (token_kind),
		.char_out    (char_out),
		.line_class  (line_class),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic cfg_t default_cfg();
		cfg_t c;
		c.sec_open   = "[";
		c.sec_close  = "]";
		c.assign_ch  = "=";
		c.cmt_first  = "#";
		c.cmt_second = "*";
		c.cmt_third  = ";";
		c.want       = WANT_ALL;
		return c;
	endfunction

	function automatic void apply_reg(inout cfg_t c, input cfg_idx_t idx, input logic [7:0] v);
		case (idx)
			CFG_SEC_OPEN:   c.sec_open   = v;
			CFG_SEC_CLOSE:  c.sec_close  = v;
			CFG_ASSIGN:     c.assign_ch  = v;
			CFG_CMT_FIRST:  c.cmt_first  = v;
			CFG_CMT_SECOND: c.cmt_second = v;
			CFG_CMT_THIRD:  c.cmt_third  = v;
			CFG_WANT_MODE:  c.want       = want_t'(v[1:0]);
			default: ;
		endcase
	endfunction

	// a zero register never matches, not even a zero byte
	function automatic logic is_comment(logic [7:0] b);
		return (model_cfg.cmt_first != CharNul && b == model_cfg.cmt_first) ||
			(model_cfg.cmt_second != CharNul && b == model_cfg.cmt_second) ||
			(model_cfg.cmt_third != CharNul && b == model_cfg.cmt_third);
	endfunction

	function automatic void queue_token(kind_t k, logic [7:0] ch);
		res_t t;
		t.kind = k;
		t.ch   = ch;
		t.cls  = line_cls;
		t.last = 1'b0;
		item_tokens.push_back(t);
	endfunction

	// a deferred collapsed space goes out ahead of the character
	function automatic void queue_collapsed(kind_t k, logic [7:0] b);
		if (space_owed) begin
			queue_token(k, CharSpace);
			space_owed = 1'b0;
		end
		queue_token(k, b);
	endfunction

	function automatic void key_step(logic [7:0] b, logic blank);
		if (blank) begin
			space_owed = 1'b1;
		end else if (b == model_cfg.assign_ch) begin
			line_cls   = CLS_KEYVAL;
			space_owed = 1'b0;
			line_phase = PH_VAL_LEAD;
		end else begin
			queue_collapsed(TK_KEY, b);
		end
	endfunction

	// Expected tokens for one accepted input transaction
	function automatic void tokenize_byte(logic [7:0] b, logic eol);
		logic blank, want_sec, want_key;
		res_t t;
		blank    = (b == CharSpace) || (b == CharTab);
		want_sec = (model_cfg.want == WANT_ALL) || (model_cfg.want == WANT_SECTIONS);
		want_key = (model_cfg.want == WANT_ALL) || (model_cfg.want == WANT_KEYS);
		item_tokens.delete();
		if (eol) begin
			// line end reports the class reached before the clear
			queue_token(TK_LINE_END, CharNul);
			line_phase = PH_LEAD;
			space_owed = 1'b0;
			line_cls   = CLS_EMPTY;
		end else begin
			case (line_phase)
				PH_LEAD: if (!blank) begin
					if (b == model_cfg.sec_open) begin
						line_cls   = CLS_SECTION;
						line_phase = want_sec ? PH_SEC_LEAD : PH_IGNORE;
					end else if (is_comment(b)) begin
						line_cls   = CLS_COMMENT;
						line_phase = PH_IGNORE;
					end else begin
						line_cls   = CLS_KEY;
						space_owed = 1'b0;
						if (want_key) begin
							line_phase = PH_KEY;
							key_step(b, 1'b0);
						end else begin
							line_phase = PH_IGNORE;
						end
					end
				end
				PH_SEC_LEAD: if (!blank) begin
					if (b == model_cfg.sec_close) begin
						line_phase = PH_IGNORE;
					end else begin
						queue_token(TK_SECTION, b);
						line_phase = PH_SEC;
					end
				end
				PH_SEC: begin
					if (blank) begin
						space_owed = 1'b1;
					end else if (b == model_cfg.sec_close) begin
						space_owed = 1'b0;
						line_phase = PH_IGNORE;
					end else begin
						queue_collapsed(TK_SECTION, b);
					end
				end
				PH_KEY: key_step(b, blank);
				PH_VAL_LEAD: if (!blank) begin
					queue_token(TK_VALUE, b);
					line_phase = PH_VAL;
				end
				PH_VAL: queue_token(TK_VALUE, b);
				default: ;
			endcase
		end
		foreach (item_tokens[k]) begin
			t = item_tokens[k];
			t.last = (k == item_tokens.size() - 1);
			expected_tokens.push_back(t);
		end
	endfunction

	// ---------------------------------------------------------------- stimulus planning

	function automatic void push_char(logic [7:0] b, logic eol);
		feed_op_t op;
		if ($urandom_range(0, 40) == 0)
			tx_idle_on = !tx_idle_on;
		op.b   = b;
		op.eol = eol;
		op.idx = CFG_SEC_OPEN;
		op.val = 8'h00;
		op.gap = tx_idle_on ? int'($urandom_range(0, 15)) : 0;
		if (op.gap != 0) begin
			op.kind = FEED_PAUSE;
			text_feed.push_back(op);
		end
		op.kind = FEED_CHAR;
		text_feed.push_back(op);
		planned_items++;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], 1'b0);
	endfunction

	// the byte lane of a line-end transaction is random; the block must ignore it
	function automatic void push_eol();
		push_char(8'($urandom_range(0, 255)), 1'b1);
	endfunction

	// register writes wait until the block has drained
	function automatic void write_reg(cfg_idx_t idx, logic [7:0] v);
		feed_op_t op;
		op.b    = 8'h00;
		op.eol  = 1'b0;
		op.idx  = idx;
		op.val  = v;
		op.gap  = 0;
		op.kind = FEED_WAIT_IDLE;
		text_feed.push_back(op);
		op.kind = FEED_REG_WRITE;
		text_feed.push_back(op);
		apply_reg(plan_cfg, idx, v);
	endfunction

	function automatic void set_all(logic [7:0] op_c, logic [7:0] cl_c, logic [7:0] as_c,
		logic [7:0] c1, logic [7:0] c2, logic [7:0] c3, logic [7:0] want);
		write_reg(CFG_SEC_OPEN, op_c);
		write_reg(CFG_SEC_CLOSE, cl_c);
		write_reg(CFG_ASSIGN, as_c);
		write_reg(CFG_CMT_FIRST, c1);
		write_reg(CFG_CMT_SECOND, c2);
		write_reg(CFG_CMT_THIRD, c3);
		write_reg(CFG_WANT_MODE, want);
	endfunction

	function automatic logic [7:0] blank_byte();
		return $urandom_range(0, 1) ? CharTab : CharSpace;
	endfunction

	function automatic logic [7:0] marker_byte();
		case ($urandom_range(0, 5))
			0: return plan_cfg.sec_open;
			1: return plan_cfg.sec_close;
			2: return plan_cfg.assign_ch;
			3: return plan_cfg.cmt_first;
			4: return plan_cfg.cmt_second;
			default: return plan_cfg.cmt_third;
		endcase
	endfunction

	// mostly letters, with blanks, current markers and arbitrary bytes mixed in
	function automatic logic [7:0] text_byte();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'h61 + 8'($urandom_range(0, 25));
			4: return 8'h30 + 8'($urandom_range(0, 9));
			5: return blank_byte();
			6, 7: return marker_byte();
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One line of random content: mostly well formed, some noise and unterminated lines
	function automatic void push_random_line();
		bit skip_eol;
		skip_eol = 1'b0;
		repeat ($urandom_range(0, 2)) push_char(blank_byte(), 1'b0);
		case ($urandom_range(0, 9))
			0, 1: begin
				push_char(plan_cfg.sec_open, 1'b0);
				repeat ($urandom_range(0, 6)) push_char(text_byte(), 1'b0);
				if ($urandom_range(0, 3) != 0)
					push_char(plan_cfg.sec_close, 1'b0);
				repeat ($urandom_range(0, 3)) push_char(text_byte(), 1'b0);
			end
			2, 3, 4: begin
				repeat ($urandom_range(0, 5)) push_char(text_byte(), 1'b0);
				push_char(plan_cfg.assign_ch, 1'b0);
				repeat ($urandom_range(0, 2)) push_char(blank_byte(), 1'b0);
				repeat ($urandom_range(0, 6)) push_char(text_byte(), 1'b0);
			end
			5: repeat ($urandom_range(1, 6)) push_char(text_byte(), 1'b0);
			6: begin
				case ($urandom_range(0, 2))
					0: push_char(plan_cfg.cmt_first, 1'b0);
					1: push_char(plan_cfg.cmt_second, 1'b0);
					default: push_char(plan_cfg.cmt_third, 1'b0);
				endcase
				repeat ($urandom_range(0, 4)) push_char(text_byte(), 1'b0);
			end
			7: ;
			default: begin
				repeat ($urandom_range(0, 8)) push_char(8'($urandom_range(0, 255)), 1'b0);
				skip_eol = ($urandom_range(0, 1) != 0);
			end
		endcase
		if (!skip_eol)
			push_eol();
	endfunction

	// ---------------------------------------------------------------- run control

	initial begin : stimulus_plan
		int goal;
		plan_cfg = default_cfg();

		// section: tab lead, blank run collapsed, tail after the close ignored
		push_text("\t[a  b]x");
		push_eol();
		// key, blank before assign, further assign kept in the value
		push_text("k\t=v=");
		push_eol();
		// comment tail
		push_text("#c");
		push_eol();
		// empty line
		push_eol();
		// key starting with assign, top byte value in the value
		push_text("=");
		push_char(8'hFF, 1'b0);
		push_eol();
		// zero data byte is an ordinary key character
		push_char(8'h00, 1'b0);
		push_eol();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: ;
				1: write_reg(CFG_WANT_MODE, 8'(WANT_SECTIONS));
				2: write_reg(CFG_WANT_MODE, 8'(WANT_KEYS));
				3: write_reg(CFG_WANT_MODE, 8'(WANT_NONE));
				// extremes; blank assign and tab comment marker never act
				4: set_all(8'h00, 8'hFF, CharSpace, CharNul, CharTab, 8'hFF, 8'(WANT_ALL));
				// open shares a character with a comment marker and wins
				5: set_all("#", ":", ":", "#", CharNul, CharNul, 8'(WANT_ALL));
				default: set_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 3)));
			endcase
			goal = planned_items + PHASE_ITEMS;
			while (planned_items < goal)
				push_random_line();
			push_eol();
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (text_feed.size() != 0 || in_valid || expected_tokens.size() != 0)
			@(negedge clk);
		repeat (4 * SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, expected_tokens.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin : feed_driver
		feed_op_t op;
		logic     nxt_in, nxt_cfg;
		if (!arst_n) begin
			in_valid     <= 1'b0;
			cfg_valid    <= 1'b0;
			model_cfg    = default_cfg();
			line_phase   = PH_LEAD;
			space_owed   = 1'b0;
			line_cls     = CLS_EMPTY;
			pause_left   = 0;
			quiet_cycles = 0;
		end else begin
			// predictor follows every transaction taken at this edge
			if (in_valid && in_ready)
				tokenize_byte(data_byte, end_of_line);
			if (cfg_valid && cfg_ready)
				apply_reg(model_cfg, cfg_index, cfg_data);

			// cycles with nothing accepted and nothing outstanding
			if ((in_valid && in_ready) || expected_tokens.size() != 0)
				quiet_cycles = 0;
			else if (quiet_cycles < SETTLE_CYCLES)
				quiet_cycles++;

			nxt_in  = 1'b0;
			nxt_cfg = 1'b0;
			if ((in_valid && !in_ready) || (cfg_valid && !cfg_ready)) begin
				// hold the pending transaction
				nxt_in  = in_valid;
				nxt_cfg = cfg_valid;
			end else if (pause_left != 0) begin
				pause_left--;
			end else if (text_feed.size() != 0) begin
				op = text_feed[0];
				case (op.kind)
					FEED_PAUSE: begin
						void'(text_feed.pop_front());
						pause_left = op.gap - 1;
					end
					FEED_CHAR: begin
						void'(text_feed.pop_front());
						nxt_in      = 1'b1;
						data_byte   <= op.b;
						end_of_line <= op.eol;
					end
					FEED_REG_WRITE: begin
						void'(text_feed.pop_front());
						nxt_cfg   = 1'b1;
						cfg_index <= op.idx;
						cfg_data  <= op.val;
					end
					default: begin
						if (expected_tokens.size() == 0 && quiet_cycles >= SETTLE_CYCLES)
							void'(text_feed.pop_front());
					end
				endcase
			end
			in_valid  <= nxt_in;
			cfg_valid <= nxt_cfg;
		end
	end

	// ---------------------------------------------------------------- monitor

	function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : token_monitor
		res_t want_tok;
		int   hold;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall  = 0;
		end else begin
			hold = rx_stall;
			if (out_valid && out_ready) begin
				if (expected_tokens.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual kind %0d char %h class %0d last %b",
						$time, token_kind, char_out, line_class, last);
				end else begin
					want_tok = expected_tokens.pop_front();
					check_field("token_kind", 8'(want_tok.kind), 8'(token_kind));
					check_field("char_out", want_tok.ch, char_out);
					check_field("line_class", 8'(want_tok.cls), 8'(line_class));
					check_field("last", 8'(want_tok.last), 8'(last));
				end
				if ($urandom_range(0, 31) == 0)
					rx_idle_on = !rx_idle_on;
				hold = rx_idle_on ? int'($urandom_range(0, 15)) : 0;
			end
			// hold out_ready low until the drawn stall has run out, then take the next transaction
			if (hold != 0) begin
				out_ready <= 1'b0;
				rx_stall  = hold - 1;
			end else begin
				out_ready <= 1'b1;
				rx_stall  = 0;
			end
		end
	end

endmodule
